/* rtl/pds_pkg.sv */
// ---------------------------------------------------------------------------
// pds_pkg
// Shared types, constants and arithmetic helpers of the Phong shader pipeline.
// ---------------------------------------------------------------------------
package pds_pkg;

	// pipeline geometry
	localparam int SQRT_STEPS  = 31;
	localparam int DIV_STEPS   = 15;
	localparam int POW_STEPS   = 8;
	localparam int SHIFT_RANGE = 8;

	// prescale bound: components must lie strictly inside +/- 2^30
	localparam logic signed [36:0] COMP_LIM = 37'sd1073741824;
	// clamp bound of the reflection-eye dot: 1.0 in Q.28
	localparam logic signed [33:0] DOT_ONE  = 34'sd268435456;
	localparam logic [15:0]        POW_ONE  = 16'd32768;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SHININESS,
		REG_LIGHT_R,
		REG_LIGHT_G,
		REG_LIGHT_B,
		REG_LIGHT_A,
		REG_CAM_X,
		REG_CAM_Y,
		REG_CAM_Z
	} pds_reg_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] ldir_x;
		logic signed [15:0] ldir_y;
		logic signed [15:0] ldir_z;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic [15:0]        albedo_r;
		logic [15:0]        albedo_g;
		logic [15:0]        albedo_b;
	} pds_in_t;

	typedef struct packed {
		logic [15:0] diff_r;
		logic [15:0] diff_g;
		logic [15:0] diff_b;
		logic [15:0] diff_a;
		logic [15:0] spec_r;
		logic [15:0] spec_g;
		logic [15:0] spec_b;
	} pds_out_t;

	typedef struct packed {
		logic [7:0]         shininess;
		logic [15:0]        light_r;
		logic [15:0]        light_g;
		logic [15:0]        light_b;
		logic [15:0]        light_a;
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
	} pds_cfg_t;

	// diffuse results (r, g, b, a) and prescaled reflection and eye vectors
	typedef struct packed {
		logic [3:0][15:0] dif;
		logic [2:0][30:0] rc;
		logic [2:0][30:0] ec;
	} pds_carry_t;

	typedef struct packed {
		pds_carry_t  cy;
		logic [61:0] rsum;
		logic [61:0] esum;
	} pds_front_t;

	// square root step state: remainder and partial root
	typedef struct packed {
		logic [61:0] x;
		logic [62:0] res;
	} pds_sq_t;

	// divider lane state
	typedef struct packed {
		logic [45:0] rem;
		logic [14:0] quo;
		logic        neg;
	} pds_div_t;

	typedef struct packed {
		logic [3:0][15:0] dif;
		logic [2:0][15:0] rdir;
		logic [2:0][15:0] edir;
	} pds_norm_t;

	typedef struct packed {
		logic [15:0] acc;
		logic [15:0] b;
	} pds_pow_t;

	function automatic logic [15:0] sat16(input logic [31:0] v);
		return (v > 32'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	// smallest arithmetic right shift that brings the value inside +/- 2^30
	function automatic logic [2:0] fit_shift(input logic signed [36:0] v);
		logic signed [36:0] t;
		logic [2:0]         k;
		k = 3'(SHIFT_RANGE - 1);
		for (int s = SHIFT_RANGE - 1; s >= 0; s--) begin
			t = v >>> s;
			if ((t < COMP_LIM) && (t > -COMP_LIM)) k = 3'(s);
		end
		return k;
	endfunction

	// one shift for the whole vector: the largest of the component shifts
	function automatic logic [2:0] vec_shift(input logic signed [36:0] a,
		input logic signed [36:0] b, input logic signed [36:0] c);
		logic [2:0] ka;
		logic [2:0] kb;
		logic [2:0] kc;
		logic [2:0] m;
		ka = fit_shift(a);
		kb = fit_shift(b);
		kc = fit_shift(c);
		m  = ka;
		if (kb > m) m = kb;
		if (kc > m) m = kc;
		return m;
	endfunction

	// one digit of the restoring square root, test bit 4^j
	function automatic pds_sq_t isqrt_step(input pds_sq_t s, input int j);
		logic [62:0] bv;
		logic [62:0] trial;
		pds_sq_t     o;
		bv    = 63'd1 << (2 * j);
		trial = s.res + bv;
		o     = s;
		if ({1'b0, s.x} >= trial) begin
			o.x   = s.x - trial[61:0];
			o.res = (s.res >> 1) + bv;
		end else begin
			o.res = s.res >> 1;
		end
		return o;
	endfunction

	// numerator is |c| in Q.14 above the component
	function automatic pds_div_t div_init(input logic [30:0] c);
		logic [30:0] mag;
		pds_div_t    o;
		mag   = c[30] ? (~c + 31'd1) : c;
		o.neg = c[30];
		o.rem = 46'(mag) << 14;
		o.quo = '0;
		return o;
	endfunction

	// one restoring quotient bit
	function automatic pds_div_t div_step(input pds_div_t d, input logic [30:0] len,
		input int j);
		logic [45:0] t;
		pds_div_t    o;
		o = d;
		t = 46'(len) << j;
		if (d.rem >= t) begin
			o.rem    = d.rem - t;
			o.quo[j] = 1'b1;
		end
		return o;
	endfunction

	// signed quotient, zero length gives a zero vector
	function automatic logic [15:0] div_result(input pds_div_t d, input logic [30:0] len);
		logic [15:0] q;
		q = {1'b0, d.quo};
		if (len == '0) return '0;
		return d.neg ? (~q + 16'd1) : q;
	endfunction

	// one bit of the square-and-multiply power
	function automatic pds_pow_t pow_step(input pds_pow_t p, input logic bitset);
		logic [31:0] pa;
		logic [31:0] pb;
		pds_pow_t    o;
		pa    = 32'(p.acc) * 32'(p.b);
		pb    = 32'(p.b) * 32'(p.b);
		o.acc = bitset ? pa[30:15] : p.acc;
		o.b   = pb[30:15];
		return o;
	endfunction

endpackage

/* rtl/pds_front.sv */
// ---------------------------------------------------------------------------
// pds_front
// Dot product, diffuse terms, reflection and eye vectors, prescale and
// squared lengths: seven pipeline stages.
// ---------------------------------------------------------------------------
module pds_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  pds_pkg::pds_in_t     item,
	input  pds_pkg::pds_cfg_t    cfg,
	output logic                 out_v,
	output pds_pkg::pds_front_t  out
);

	logic signed [15:0] n_in [3];
	logic signed [15:0] l_in [3];
	logic signed [31:0] o_in [3];
	logic signed [31:0] cam  [3];
	logic [15:0]        a_in [3];
	logic [15:0]        lc   [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [31:0] nl_s1  [3];
	logic signed [32:0] eye_s1 [3];
	logic signed [15:0] n_s1   [3];
	logic signed [15:0] l_s1   [3];
	logic [15:0]        alb_s1 [3];

	logic signed [33:0] d_s2;
	logic signed [32:0] eye_s2 [3];
	logic signed [15:0] n_s2   [3];
	logic signed [15:0] l_s2   [3];
	logic [15:0]        alb_s2 [3];

	logic [19:0]        cl_s3  [3];
	logic [15:0]        da_s3;
	logic signed [49:0] rp_s3  [3];
	logic signed [15:0] l_s3   [3];
	logic [15:0]        alb_s3 [3];
	logic signed [32:0] eye_s3 [3];

	logic [3:0][15:0]   dif_s4;
	logic signed [36:0] r_s4   [3];
	logic signed [32:0] eye_s4 [3];

	logic [3:0][15:0]   dif_s5;
	logic signed [30:0] rc_s5  [3];
	logic signed [30:0] ec_s5  [3];

	logic [3:0][15:0]   dif_s6;
	logic signed [30:0] rc_s6  [3];
	logic signed [30:0] ec_s6  [3];
	logic [59:0]        rq_s6  [3];
	logic [59:0]        eq_s6  [3];

	pds_pkg::pds_front_t front_s7;

	logic [31:0]        p;
	logic [47:0]        lp  [3];
	logic [47:0]        lpa;
	logic [35:0]        ca  [3];
	logic signed [49:0] rsh [3];
	logic signed [61:0] rsq [3];
	logic signed [61:0] esq [3];
	logic signed [36:0] e37 [3];
	logic [2:0]         rk;
	logic [2:0]         ek;
	logic signed [36:0] rsc [3];
	logic signed [36:0] esc [3];

	// item fields as lanes
	assign n_in[0] = item.normal_x;
	assign n_in[1] = item.normal_y;
	assign n_in[2] = item.normal_z;
	assign l_in[0] = item.ldir_x;
	assign l_in[1] = item.ldir_y;
	assign l_in[2] = item.ldir_z;
	assign o_in[0] = item.origin_x;
	assign o_in[1] = item.origin_y;
	assign o_in[2] = item.origin_z;
	assign a_in[0] = item.albedo_r;
	assign a_in[1] = item.albedo_g;
	assign a_in[2] = item.albedo_b;
	assign cam[0]  = cfg.cam_x;
	assign cam[1]  = cfg.cam_y;
	assign cam[2]  = cfg.cam_z;
	assign lc[0]   = cfg.light_r;
	assign lc[1]   = cfg.light_g;
	assign lc[2]   = cfg.light_b;

	// multipliers feeding stages three, four and six, prescale of stage five
	always_comb begin
		p   = (d_s2 > 34'sd0) ? d_s2[31:0] : 32'd0;
		lpa = 48'(cfg.light_a) * 48'(p);
		for (int i = 0; i < 3; i++) begin
			e37[i] = 37'(eye_s4[i]);
		end
		rk = pds_pkg::vec_shift(r_s4[0], r_s4[1], r_s4[2]);
		ek = pds_pkg::vec_shift(e37[0], e37[1], e37[2]);
		for (int i = 0; i < 3; i++) begin
			lp[i]  = 48'(lc[i]) * 48'(p);
			ca[i]  = 36'(cl_s3[i]) * 36'(alb_s3[i]);
			rsh[i] = rp_s3[i] >>> 13;
			rsc[i] = r_s4[i] >>> rk;
			esc[i] = e37[i] >>> ek;
			rsq[i] = 62'(rc_s5[i]) * 62'(rc_s5[i]);
			esq[i] = 62'(ec_s5[i]) * 62'(ec_s5[i]);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// data path
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: n*l products, eye vector
			for (int i = 0; i < 3; i++) begin
				nl_s1[i]  <= 32'(n_in[i]) * 32'(l_in[i]);
				eye_s1[i] <= 33'(cam[i]) - 33'(o_in[i]);
				n_s1[i]   <= n_in[i];
				l_s1[i]   <= l_in[i];
				alb_s1[i] <= a_in[i];
			end
			// stage 2: n dot l
			d_s2 <= 34'(nl_s1[0]) + 34'(nl_s1[1]) + 34'(nl_s1[2]);
			for (int i = 0; i < 3; i++) begin
				eye_s2[i] <= eye_s1[i];
				n_s2[i]   <= n_s1[i];
				l_s2[i]   <= l_s1[i];
				alb_s2[i] <= alb_s1[i];
			end
			// stage 3: light times clamped dot, d times normal
			da_s3 <= pds_pkg::sat16(32'(lpa[47:28]));
			for (int i = 0; i < 3; i++) begin
				cl_s3[i]  <= lp[i][47:28];
				rp_s3[i]  <= 50'(d_s2) * 50'(n_s2[i]);
				l_s3[i]   <= l_s2[i];
				alb_s3[i] <= alb_s2[i];
				eye_s3[i] <= eye_s2[i];
			end
			// stage 4: albedo scaling, reflection vector
			dif_s4[3] <= da_s3;
			for (int i = 0; i < 3; i++) begin
				dif_s4[i] <= pds_pkg::sat16(32'(ca[i][35:15]));
				r_s4[i]   <= rsh[i][36:0] - (37'(l_s3[i]) <<< 14);
				eye_s4[i] <= eye_s3[i];
			end
			// stage 5: one prescale shift per vector into 31 bits
			dif_s5 <= dif_s4;
			for (int i = 0; i < 3; i++) begin
				rc_s5[i] <= rsc[i][30:0];
				ec_s5[i] <= esc[i][30:0];
			end
			// stage 6: squares
			dif_s6 <= dif_s5;
			for (int i = 0; i < 3; i++) begin
				rq_s6[i] <= rsq[i][59:0];
				eq_s6[i] <= esq[i][59:0];
				rc_s6[i] <= rc_s5[i];
				ec_s6[i] <= ec_s5[i];
			end
			// stage 7: squared lengths
			front_s7.rsum   <= 62'(rq_s6[0]) + 62'(rq_s6[1]) + 62'(rq_s6[2]);
			front_s7.esum   <= 62'(eq_s6[0]) + 62'(eq_s6[1]) + 62'(eq_s6[2]);
			front_s7.cy.dif <= dif_s6;
			for (int i = 0; i < 3; i++) begin
				front_s7.cy.rc[i] <= rc_s6[i];
				front_s7.cy.ec[i] <= ec_s6[i];
			end
		end
	end

	assign out_v = v_s7;
	assign out   = front_s7;

endmodule

/* rtl/pds_norm.sv */
// ---------------------------------------------------------------------------
// pds_norm
// Normalizes the reflection and eye vectors: a pipelined square root of the
// squared length, one root bit a stage, then a pipelined restoring divider,
// one quotient bit a stage, for all six components.
// ---------------------------------------------------------------------------
module pds_norm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  pds_pkg::pds_front_t  fr,
	output logic                 out_v,
	output pds_pkg::pds_norm_t   nm
);

	localparam int SQ = pds_pkg::SQRT_STEPS;
	localparam int DV = pds_pkg::DIV_STEPS;

	pds_pkg::pds_sq_t    rsq_s [1:SQ];
	pds_pkg::pds_sq_t    esq_s [1:SQ];
	pds_pkg::pds_carry_t cy_s  [1:SQ];
	logic                sqv_s [1:SQ];

	pds_pkg::pds_div_t [2:0] rdv_s [1:DV];
	pds_pkg::pds_div_t [2:0] edv_s [1:DV];
	logic [30:0]             rlen_s [1:DV];
	logic [30:0]             elen_s [1:DV];
	logic [3:0][15:0]        dif_s  [1:DV];
	logic                    dvv_s  [1:DV];

	pds_pkg::pds_div_t [2:0] rdv_init;
	pds_pkg::pds_div_t [2:0] edv_init;

	// square root, one bit per stage
	for (genvar g = 0; g < SQ; g++) begin : g_sqrt
		pds_pkg::pds_sq_t    r_src;
		pds_pkg::pds_sq_t    e_src;
		pds_pkg::pds_carry_t c_src;
		logic                v_src;

		if (g == 0) begin : g_head
			assign r_src = {fr.rsum, 63'd0};
			assign e_src = {fr.esum, 63'd0};
			assign c_src = fr.cy;
			assign v_src = in_v;
		end else begin : g_body
			assign r_src = rsq_s[g];
			assign e_src = esq_s[g];
			assign c_src = cy_s[g];
			assign v_src = sqv_s[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[g+1] <= 1'b0;
			end else if (en) begin
				sqv_s[g+1] <= v_src;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rsq_s[g+1] <= pds_pkg::isqrt_step(r_src, SQ - 1 - g);
				esq_s[g+1] <= pds_pkg::isqrt_step(e_src, SQ - 1 - g);
				cy_s[g+1]  <= c_src;
			end
		end
	end

	// divider lanes start from the prescaled components
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rdv_init[i] = pds_pkg::div_init(cy_s[SQ].rc[i]);
			edv_init[i] = pds_pkg::div_init(cy_s[SQ].ec[i]);
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar g = 0; g < DV; g++) begin : g_div
		pds_pkg::pds_div_t [2:0] r_src;
		pds_pkg::pds_div_t [2:0] e_src;
		logic [30:0]             rl_src;
		logic [30:0]             el_src;
		logic [3:0][15:0]        d_src;
		logic                    v_src;

		if (g == 0) begin : g_head
			assign r_src  = rdv_init;
			assign e_src  = edv_init;
			assign rl_src = rsq_s[SQ].res[30:0];
			assign el_src = esq_s[SQ].res[30:0];
			assign d_src  = cy_s[SQ].dif;
			assign v_src  = sqv_s[SQ];
		end else begin : g_body
			assign r_src  = rdv_s[g];
			assign e_src  = edv_s[g];
			assign rl_src = rlen_s[g];
			assign el_src = elen_s[g];
			assign d_src  = dif_s[g];
			assign v_src  = dvv_s[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[g+1] <= 1'b0;
			end else if (en) begin
				dvv_s[g+1] <= v_src;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					rdv_s[g+1][i] <= pds_pkg::div_step(r_src[i], rl_src, DV - 1 - g);
					edv_s[g+1][i] <= pds_pkg::div_step(e_src[i], el_src, DV - 1 - g);
				end
				rlen_s[g+1] <= rl_src;
				elen_s[g+1] <= el_src;
				dif_s[g+1]  <= d_src;
			end
		end
	end

	// signed unit vectors in Q2.14
	always_comb begin
		nm.dif = dif_s[DV];
		for (int i = 0; i < 3; i++) begin
			nm.rdir[i] = pds_pkg::div_result(rdv_s[DV][i], rlen_s[DV]);
			nm.edir[i] = pds_pkg::div_result(edv_s[DV][i], elen_s[DV]);
		end
	end

	assign out_v = dvv_s[DV];

endmodule

/* rtl/pds_spec.sv */
// ---------------------------------------------------------------------------
// pds_spec
// Reflection-eye dot, clamp, integer power by square and multiply, one
// exponent bit a stage, light scaling and the output register.
// ---------------------------------------------------------------------------
module pds_spec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  pds_pkg::pds_norm_t  nm,
	input  pds_pkg::pds_cfg_t   cfg,
	output logic                out_v,
	output pds_pkg::pds_out_t   res
);

	localparam int PW = pds_pkg::POW_STEPS;

	logic               v_s1, v_s2, v_s3;
	logic signed [31:0] pr_s1 [3];
	logic [3:0][15:0]   dif_s1;
	logic [15:0]        s_s2;
	logic [3:0][15:0]   dif_s2;

	pds_pkg::pds_pow_t pw_s   [1:PW];
	logic [3:0][15:0]  pdif_s [1:PW];
	logic              pwv_s  [1:PW];

	pds_pkg::pds_out_t res_s3;

	logic signed [31:0] pr [3];
	logic signed [33:0] dsum;
	logic [28:0]        dclamp;
	logic [31:0]        sp [3];

	// products, clamp and light scaling
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pr[i] = 32'($signed(nm.rdir[i])) * 32'($signed(nm.edir[i]));
		end
		dsum = 34'(pr_s1[0]) + 34'(pr_s1[1]) + 34'(pr_s1[2]);
		if (dsum < 34'sd0) begin
			dclamp = '0;
		end else if (dsum > pds_pkg::DOT_ONE) begin
			dclamp = pds_pkg::DOT_ONE[28:0];
		end else begin
			dclamp = dsum[28:0];
		end
		sp[0] = 32'(cfg.light_r) * 32'(pw_s[PW].acc);
		sp[1] = 32'(cfg.light_g) * 32'(pw_s[PW].acc);
		sp[2] = 32'(cfg.light_b) * 32'(pw_s[PW].acc);
	end

	// valid bits of the dot stages and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= pwv_s[PW];
		end
	end

	// dot stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pr_s1[i] <= pr[i];
			end
			dif_s1 <= nm.dif;
			s_s2   <= dclamp[28:13];
			dif_s2 <= dif_s1;
		end
	end

	// power, exponent bits lsb first
	for (genvar g = 0; g < PW; g++) begin : g_pow
		pds_pkg::pds_pow_t p_src;
		logic [3:0][15:0]  d_src;
		logic              v_src;

		if (g == 0) begin : g_head
			assign p_src = {pds_pkg::POW_ONE, s_s2};
			assign d_src = dif_s2;
			assign v_src = v_s2;
		end else begin : g_body
			assign p_src = pw_s[g];
			assign d_src = pdif_s[g];
			assign v_src = pwv_s[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pwv_s[g+1] <= 1'b0;
			end else if (en) begin
				pwv_s[g+1] <= v_src;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pw_s[g+1]   <= pds_pkg::pow_step(p_src, cfg.shininess[g]);
				pdif_s[g+1] <= d_src;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			res_s3.diff_r <= pdif_s[PW][0];
			res_s3.diff_g <= pdif_s[PW][1];
			res_s3.diff_b <= pdif_s[PW][2];
			res_s3.diff_a <= pdif_s[PW][3];
			res_s3.spec_r <= pds_pkg::sat16(32'(sp[0][31:15]));
			res_s3.spec_g <= pds_pkg::sat16(32'(sp[1][31:15]));
			res_s3.spec_b <= pds_pkg::sat16(32'(sp[2][31:15]));
		end
	end

	assign out_v = v_s3;
	assign res   = res_s3;

endmodule

/* rtl/phong_diffuse_specular_shader.sv */
// ---------------------------------------------------------------------------
// phong_diffuse_specular_shader
// Fixed-point Phong shading: diffuse and specular colour for each fragment.
// ---------------------------------------------------------------------------
// The shader takes one request per clock while the output is not held and
// returns one result per request, in order. Each request passes through a
// single pipeline: seven front stages (dot product, diffuse, reflection and
// eye vectors, squared lengths), a 31-stage square root, a 15-stage divider
// for the unit vectors, and eleven specular stages (dot, clamp, an eight-
// stage power by the shininess bits, light scaling into the output register).
// While a result waits at the output the whole pipeline holds and item_ready
// is low. Configuration registers take effect for requests accepted after the
// write and must only be written while no request is in flight.
module phong_diffuse_specular_shader (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  pds_pkg::pds_in_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output pds_pkg::pds_out_t  result,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	pds_pkg::pds_cfg_t   cfg_q;
	logic                adv;
	logic                front_v;
	pds_pkg::pds_front_t front;
	logic                norm_v;
	pds_pkg::pds_norm_t  norm;

	// pipeline advances unless the output register is held
	assign adv        = !result_valid || result_ready;
	assign item_ready = adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shininess <= 8'd32;
			cfg_q.light_r   <= 16'd32768;
			cfg_q.light_g   <= 16'd32768;
			cfg_q.light_b   <= 16'd32768;
			cfg_q.light_a   <= 16'd32768;
			cfg_q.cam_x     <= '0;
			cfg_q.cam_y     <= '0;
			cfg_q.cam_z     <= '0;
		end else if (cfg_we) begin
			case (pds_pkg::pds_reg_t'(cfg_index))
				pds_pkg::REG_SHININESS: cfg_q.shininess <= cfg_data[7:0];
				pds_pkg::REG_LIGHT_R:   cfg_q.light_r   <= cfg_data[15:0];
				pds_pkg::REG_LIGHT_G:   cfg_q.light_g   <= cfg_data[15:0];
				pds_pkg::REG_LIGHT_B:   cfg_q.light_b   <= cfg_data[15:0];
				pds_pkg::REG_LIGHT_A:   cfg_q.light_a   <= cfg_data[15:0];
				pds_pkg::REG_CAM_X:     cfg_q.cam_x     <= cfg_data;
				pds_pkg::REG_CAM_Y:     cfg_q.cam_y     <= cfg_data;
				pds_pkg::REG_CAM_Z:     cfg_q.cam_z     <= cfg_data;
				default: ;
			endcase
		end
	end

	pds_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_v   (item_valid),
		.item   (item),
		.cfg    (cfg_q),
		.out_v  (front_v),
		.out    (front)
	);

	pds_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_v   (front_v),
		.fr     (front),
		.out_v  (norm_v),
		.nm     (norm)
	);

	pds_spec u_spec (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_v   (norm_v),
		.nm     (norm),
		.cfg    (cfg_q),
		.out_v  (result_valid),
		.res    (result)
	);

`ifndef SYNTHESIS
	// zero exponent gives a factor of exactly one
	a_spec_unit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && cfg_q.shininess == 8'd0 |->
		result.spec_r == cfg_q.light_r && result.spec_g == cfg_q.light_g &&
		result.spec_b == cfg_q.light_b)
		else $error("specular not equal to light colour at zero shininess");

	// dark light alpha leaves no diffuse alpha
	a_alpha_dark: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && cfg_q.light_a == 16'd0 |-> result.diff_a == 16'd0)
		else $error("diffuse alpha set under zero light alpha");

	// dark red light leaves no red in either term
	a_red_dark: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && cfg_q.light_r == 16'd0 |->
		result.diff_r == 16'd0 && result.spec_r == 16'd0)
		else $error("red output set under zero red light");
`endif

endmodule
